@@ rtl/core/mbps_pkg.sv @@
// masked byte pattern search: shared types and constants
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package mbps_pkg;

  // fixed field widths
  localparam int PatBytes = 16;
  localparam int PatW     = 8 * PatBytes;
  localparam int LenW     = 5;
  localparam int AddrW    = 32;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPatLow   = 3'd0,
    RegPatHigh  = 3'd1,
    RegCareMask = 3'd2,
    RegPatLen   = 3'd3,
    RegBase     = 3'd4,
    RegOffset   = 3'd5,
    RegBackward = 3'd6
  } cfg_reg_e;

  // settings handed from the register file to the match logic
  typedef struct packed {
    logic [PatW-1:0]     pattern;   // byte k in bits 8k+7..8k
    logic [PatBytes-1:0] care;
    logic [LenW-1:0]     len;       // clamped, 1..PATTERN_MAX
    logic [AddrW-1:0]    addr_adj;  // base - (len - 1)
    logic [AddrW-1:0]    offset;    // added to the kept start on the result
    logic                backward;
  } cfg_t;

endpackage

@@ rtl/core/mbps_cfg.sv @@
// masked byte pattern search: configuration registers
// depends on mbps_pkg
`timescale 1ns / 1ps

module mbps_cfg #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mbps_pkg::CfgDataW-1:0]       cfg_data_i,
  output mbps_pkg::cfg_t                      cfg_o
);

  logic [63:0]                     pat_lo_q;
  logic [63:0]                     pat_hi_q;
  logic [mbps_pkg::PatBytes-1:0]   care_q;
  logic [mbps_pkg::LenW-1:0]       len_raw_q;
  logic [mbps_pkg::AddrW-1:0]      base_q;
  logic [mbps_pkg::AddrW-1:0]      offset_q;
  logic                            backward_q;
  logic [mbps_pkg::LenW-1:0]       len_lo;
  logic [mbps_pkg::LenW-1:0]       len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q   <= '0;
      pat_hi_q   <= '0;
      care_q     <= '1;
      len_raw_q  <= mbps_pkg::LenW'(1);
      base_q     <= '0;
      offset_q   <= '0;
      backward_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (mbps_pkg::cfg_reg_e'(cfg_index_i))
        mbps_pkg::RegPatLow:   pat_lo_q   <= cfg_data_i;
        mbps_pkg::RegPatHigh:  pat_hi_q   <= cfg_data_i;
        mbps_pkg::RegCareMask: care_q     <= cfg_data_i[mbps_pkg::PatBytes-1:0];
        mbps_pkg::RegPatLen:   len_raw_q  <= cfg_data_i[mbps_pkg::LenW-1:0];
        mbps_pkg::RegBase:     base_q     <= cfg_data_i[mbps_pkg::AddrW-1:0];
        mbps_pkg::RegOffset:   offset_q   <= cfg_data_i[mbps_pkg::AddrW-1:0];
        mbps_pkg::RegBackward: backward_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the window depth as the depth
  always_comb begin
    len_lo  = (len_raw_q == '0) ? mbps_pkg::LenW'(1) : len_raw_q;
    len_eff = (int'(len_lo) > PATTERN_MAX) ? mbps_pkg::LenW'(PATTERN_MAX) : len_lo;
  end

  assign cfg_o.pattern  = {pat_hi_q, pat_lo_q};
  assign cfg_o.care     = care_q;
  assign cfg_o.len      = len_eff;
  assign cfg_o.addr_adj = base_q - mbps_pkg::AddrW'(len_eff - mbps_pkg::LenW'(1));
  assign cfg_o.offset   = offset_q;
  assign cfg_o.backward = backward_q;

endmodule

@@ rtl/core/mbps_match.sv @@
// masked byte pattern search: byte window, masked compare and kept match
// depends on mbps_pkg
`timescale 1ns / 1ps

module mbps_match #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          last_i,
  input  logic [7:0]                    byte_i,
  input  mbps_pkg::cfg_t                cfg_i,
  output logic                          found_o,
  output logic [mbps_pkg::AddrW-1:0]    addr_o
);

  localparam int IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int KMax = (PATTERN_MAX < mbps_pkg::PatBytes) ? PATTERN_MAX
                                                           : mbps_pkg::PatBytes;

  logic [7:0]                  win_q [PATTERN_MAX];
  logic [7:0]                  win_d [PATTERN_MAX];
  logic [31:0]                 seen_q;
  logic                        have_q;
  logic [mbps_pkg::AddrW-1:0]  kept_q;
  logic                        hit;
  logic                        cmp_en;
  logic                        take;
  logic                        have_next;
  logic [mbps_pkg::AddrW-1:0]  kept_next;

  // window[0] is the newest byte
  always_comb begin
    win_d[0] = byte_i;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  // pattern byte k lines up with the byte len-1-k steps back
  always_comb begin
    logic [6:0] idx;
    hit = 1'b1;
    for (int k = 0; k < KMax; k++) begin
      idx = 7'(cfg_i.len) - 7'd1 - 7'(k);
      if ((mbps_pkg::LenW'(k) < cfg_i.len) && ((k == 0) || cfg_i.care[k]) &&
          (win_d[idx[IdxW-1:0]] != cfg_i.pattern[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  // kept start is region address; the offset is added on the way out
  always_comb begin
    cmp_en    = seen_q >= 32'(cfg_i.len - mbps_pkg::LenW'(1));
    take      = cmp_en && hit && (cfg_i.backward || !have_q);
    have_next = have_q || take;
    kept_next = take ? (cfg_i.addr_adj + seen_q) : kept_q;
  end

  assign found_o = have_next;
  assign addr_o  = have_next ? (kept_next + cfg_i.offset) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      have_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        seen_q <= '0;
        have_q <= 1'b0;
      end else begin
        seen_q <= (seen_q != '1) ? seen_q + 32'd1 : seen_q;
        have_q <= have_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      win_q  <= win_d;
      kept_q <= kept_next;
    end
  end

endmodule

@@ rtl/core/masked_byte_pattern_search.sv @@
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------
//  in       | in        | in_valid_i / in_ready_o | data_byte_i, last_byte_i
//  out      | out       | out_valid_o/ out_ready_i| found_o, match_address_o
//  cfg      | in        | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
//  one byte a cycle unless stalled; a word sits in the input register while
//  the compare and match update run on it, and a last word then loads the
//  result into the output register, from which the result can be taken
//  the input side stalls only when a last byte waits on a full output register
//  asynchronous active-low reset clears valid flags, count and kept match;
//  configuration resets to pattern 0, full care mask, length one
//  depends on mbps_pkg, mbps_cfg, mbps_match
`timescale 1ns / 1ps

module masked_byte_pattern_search #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // byte input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               last_byte_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               found_o,
  output logic [mbps_pkg::AddrW-1:0]         match_address_o,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [mbps_pkg::CfgDataW-1:0]      cfg_data_i
);

  mbps_pkg::cfg_t              cfg;

  // input register
  logic                        in_vld_q;
  logic                        in_vld_d;
  logic [7:0]                  in_byte_q;
  logic                        in_last_q;
  logic                        in_fire;

  // output register
  logic                        out_vld_q;
  logic                        out_vld_d;
  logic                        out_found_q;
  logic [mbps_pkg::AddrW-1:0]  out_addr_q;
  logic                        out_free;

  // match stage
  logic                        step;
  logic                        res_found;
  logic [mbps_pkg::AddrW-1:0]  res_addr;

  mbps_cfg #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_vld_q || out_ready_i;

  // a non-last word always moves on; a last word needs the result slot
  assign step       = in_vld_q && (!in_last_q || out_free);
  assign in_ready_o = !in_vld_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (step && in_last_q) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  mbps_match #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .last_i  (in_last_q),
    .byte_i  (in_byte_q),
    .cfg_i   (cfg),
    .found_o (res_found),
    .addr_o  (res_addr)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
    if (step && in_last_q) begin
      out_found_q <= res_found;
      out_addr_q  <= res_addr;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign found_o         = out_found_q;
  assign match_address_o = out_addr_q;

endmodule

@@ rtl/core/mbps_checker.sv @@
// masked byte pattern search: port-level checker and its bind
// depends on masked_byte_pattern_search ports and mbps_pkg widths
`timescale 1ns / 1ps

module mbps_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            last_byte_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            found_o,
  input logic [mbps_pkg::AddrW-1:0]      match_address_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) &&
    $stable(match_address_o))
    else $error("result word changed while stalled");

  // no match reports address zero
  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_address_o == '0)
    else $error("address nonzero without a match");

  // input only stalls behind a full result slot
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result slot");

  // a fresh result follows an accepted last word
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_byte_i, 2))
    else $error("result without a preceding last word");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (.*);
